[sv/bba_pkg.sv]
// Package for the bitmap block allocator: field widths, request and status codes,
// and the control struct that the sequencer hands to the run counter.
// Depends on nothing; bba_run_unit and bitmap_block_allocator import it.
package bba_pkg;

    localparam int BLOCKS_DEFAULT = 64;

    localparam int START_W  = 6;
    localparam int LENGTH_W = 7;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 7;
    localparam int DATA_W   = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic clear;
        logic step;
        logic used;
    } run_ctl_t;

endpackage

[sv/bba_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/bba_run_unit.sv]
// Free-run counter for the first-fit search: counts consecutive free blocks and
// flags the cycle on which the run reaches the requested length. Uses bba_pkg.
module bba_run_unit #(
    parameter int BLOCKS = bba_pkg::BLOCKS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bba_pkg::run_ctl_t         ctl,
    input  logic [$clog2(BLOCKS+1)-1:0] len,
    output logic                      hit
);
    import bba_pkg::*;

    localparam int CNT_W = $clog2(BLOCKS + 1);

    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic [CNT_W-1:0] run_inc;

    assign run_inc = run_reg + CNT_W'(1);
    assign hit     = ctl.step && !ctl.used && (run_inc == len);

    always_comb
    begin
        run_next = run_reg;
        if (ctl.clear)
        begin
            run_next = '0;
        end
        else if (ctl.step)
        begin
            run_next = ctl.used ? '0 : run_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

[sv/bitmap_block_allocator.sv]
// Top level of the bitmap first-fit block allocator: sequencer, usage map RAM,
// free counter and output register. Uses bba_pkg, bba_ram and bba_run_unit.
//
//  Channel  | Dir | Handshake                    | Payload
//  ---------+-----+------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid, s_axis_tready | tuser: operation; tdata: start, length
//  m_axis   | out | m_axis_tvalid, m_axis_tready | tdata: status, block_start, free_blocks
//
// After reset the block sweeps the usage map RAM to zero, one block per cycle, over
// all BLOCKS entries; s_axis_tready stays low during that sweep.
// A rejected request goes from the accepting state straight to the result state; a
// free request reads its run one block ahead of the writes that clear it.
// An allocate request scans the map one block per cycle through the single RAM read
// port and, if it finds a run, then marks that run used block by block.
// The result sits in an output register, so a stalled m_axis side does not stop the
// next request from being accepted; it only holds completion of that next request.
module bitmap_block_allocator #(
    parameter int BLOCKS = bba_pkg::BLOCKS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata bits from low up: start_block[5:0], run_length[12:6], zero fill
    input  logic [bba_pkg::DATA_W-1:0]  s_axis_tdata,
    // tuser: operation (0 allocate, 1 free)
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata bits from low up: status[1:0], block_start[7:2], free_blocks[14:8], zero fill
    output logic [bba_pkg::DATA_W-1:0]  m_axis_tdata
);
    import bba_pkg::*;

    localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int WIDE_W = ((CNT_W > LENGTH_W) ? CNT_W : LENGTH_W) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCKS - 1);

    // Control state.
    logic [2:0]       state_reg,    state_next;
    logic [IDX_W-1:0] addr_reg,     addr_next;
    logic             pend_reg,     pend_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [CNT_W-1:0] evcnt_reg,    evcnt_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state.
    logic [IDX_W-1:0]    pidx_reg,       pidx_next;
    logic [IDX_W-1:0]    base_reg,       base_next;
    logic [CNT_W-1:0]    len_reg,        len_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [START_W-1:0]  res_start_reg,  res_start_next;
    logic [DATA_W-1:0]   out_data_reg,   out_data_next;

    // RAM and run unit connections.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [0:0]       ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [0:0]       ram_rdata;
    run_ctl_t         run_ctl;
    logic             run_hit;

    // Request decode, done in a width that holds every sum without overflow.
    logic [WIDE_W-1:0] len_wide;
    logic [WIDE_W-1:0] start_wide;
    logic              bad_len;
    logic              bad_range;
    logic [CNT_W-1:0]  found_base;
    logic [WIDE_W-1:0] base_wide;
    logic [WIDE_W-1:0] free_wide;
    logic [IDX_W-1:0]  addr_inc;

    assign len_wide   = WIDE_W'(s_axis_tdata[START_W +: LENGTH_W]);
    assign start_wide = WIDE_W'(s_axis_tdata[START_W-1:0]);
    assign bad_len    = (len_wide == '0) || (len_wide > WIDE_W'(BLOCKS));
    assign bad_range  = (start_wide >= WIDE_W'(BLOCKS))
                     || ((start_wide + len_wide) > WIDE_W'(BLOCKS));

    // The run ends at the block just read, so it starts len - 1 blocks earlier.
    assign found_base = CNT_W'(pidx_reg) + CNT_W'(1) - len_reg;
    assign base_wide  = WIDE_W'(base_reg);
    assign free_wide  = WIDE_W'(free_cnt_reg);
    assign addr_inc   = (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    bba_ram #(
        .WIDTH (1),
        .DEPTH (BLOCKS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_run_unit #(
        .BLOCKS (BLOCKS)
    ) u_run (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (run_ctl),
        .len   (len_reg),
        .hit   (run_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        evcnt_next      = evcnt_reg;
        free_cnt_next   = free_cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        pidx_next       = pidx_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        run_ctl         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_inc;
                if (addr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    len_next       = len_wide[CNT_W-1:0];
                    res_start_next = '0;
                    pend_next      = 1'b0;
                    if (bad_len)
                    begin
                        res_status_next = ST_BAD_LEN;
                        state_next      = S_DONE;
                    end
                    else if (s_axis_tuser == OP_ALLOC)
                    begin
                        addr_next     = '0;
                        run_ctl.clear = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else if (bad_range)
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        addr_next  = start_wide[IDX_W-1:0];
                        cnt_next   = len_wide[CNT_W-1:0];
                        evcnt_next = len_wide[CNT_W-1:0];
                        state_next = S_FREE;
                    end
                end
            end

            S_SCAN:
            begin
                // Read one block ahead while judging the block read last cycle.
                ram_re    = 1'b1;
                pend_next = 1'b1;
                pidx_next = addr_reg;
                addr_next = addr_inc;
                if (pend_reg)
                begin
                    run_ctl.step = 1'b1;
                    run_ctl.used = ram_rdata[0];
                    if (run_hit)
                    begin
                        base_next  = found_base[IDX_W-1:0];
                        addr_next  = found_base[IDX_W-1:0];
                        cnt_next   = len_reg;
                        state_next = S_MARK;
                    end
                    else if (pidx_reg == LAST_IDX)
                    begin
                        res_status_next = ST_NO_ROOM;
                        state_next      = S_DONE;
                    end
                end
            end

            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = 1'b1;
                addr_next = addr_inc;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    free_cnt_next   = free_cnt_reg - len_reg;
                    res_status_next = ST_OK;
                    res_start_next  = base_wide[START_W-1:0];
                    state_next      = S_DONE;
                end
            end

            S_FREE:
            begin
                // Reads run one block ahead of the clearing writes.
                pend_next = 1'b0;
                if (cnt_reg != '0)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = addr_reg;
                    addr_next = addr_inc;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = pidx_reg;
                    free_cnt_next = free_cnt_reg + CNT_W'(ram_rdata[0]);
                    evcnt_next    = evcnt_reg - CNT_W'(1);
                    if (evcnt_reg == CNT_W'(1))
                    begin
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = DATA_W'({free_wide[FREE_W-1:0], res_start_reg,
                                              res_status_reg});
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            evcnt_reg     <= '0;
            free_cnt_reg  <= CNT_W'(BLOCKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            evcnt_reg     <= evcnt_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        base_reg       <= base_next;
        len_reg        <= len_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        out_data_reg   <= out_data_next;
    end

    // The free count can never exceed the pool size.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= CNT_W'(BLOCKS))
        else $error("free count above pool size");

    // No request is taken while the map is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during map clear");

    // A run being marked must fit in the blocks counted as free.
    a_mark_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (free_cnt_reg >= len_reg))
        else $error("marking a run larger than the free count");

    // A finished result waits while the output register holds a result not being taken.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !m_axis_tready)
        |=> (state_reg == S_DONE))
        else $error("result overwrote an untaken output");

endmodule
